// ----- rtl/gaf_pkg.sv -----
// Shared types and constants for the grant admission filter.
package gaf_pkg;

	localparam int NODE_W = 8;
	localparam int SEQ_W = 64;
	localparam int TIME_W = 64;
	localparam int CNT_W = 32;
	localparam int CNT_NUM = 7;

	localparam int CNT_RECEIVED = 0;
	localparam int CNT_ACCEPTED = 1;
	localparam int CNT_BAD_SOURCE = 2;
	localparam int CNT_WRONG_TARGET = 3;
	localparam int CNT_EXPIRED = 4;
	localparam int CNT_DUPLICATE = 5;
	localparam int CNT_STALE = 6;

	typedef enum logic [2:0] {
		DEC_ACCEPT = 3'd0,
		DEC_BAD_SOURCE = 3'd1,
		DEC_WRONG_TARGET = 3'd2,
		DEC_EXPIRED = 3'd3,
		DEC_DUPLICATE = 3'd4,
		DEC_STALE = 3'd5
	} decision_t;

	// first member sits in the highest bits, so src_id lands at bit 0
	typedef struct packed {
		logic [TIME_W-1:0] current_time_ms;
		logic [TIME_W-1:0] expiry_time_ms;
		logic [SEQ_W-1:0]  sequence_number;
		logic [NODE_W-1:0] dst_id;
		logic [NODE_W-1:0] src_id;
	} grant_t;

	localparam int GRANT_W = $bits(grant_t);

	typedef logic [CNT_NUM-1:0][CNT_W-1:0] cnt_arr_t;

	// sequence history held between items
	typedef struct packed {
		logic             seen_any;
		logic [SEQ_W-1:0] last_seq;
	} seq_state_t;

endpackage

// ----- rtl/grant_admission_filter_top.sv -----
// Grant admission filter top level: input register, check stage, result register.
// Each grant item runs through an input register and then one decision stage that
// applies the source, target, expiry, duplicate and stale checks in that order, updates
// the last accepted sequence and the seven saturating counters, and loads the result
// register. One item is taken per clock unless the output stalls; an item waits in the
// input register until the result register is free, the sequence history and counters
// being read and written in that single decision stage. The input register only holds
// while the result register is full and m_tready is low. m_tdata always shows the
// counters as they stand after the item held in the result register. The user must
// write the own node id through cfg_we/cfg_wdata only while idle; nothing enforces it.
module grant_admission_filter_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [7:0]   cfg_wdata,     // own node id
	input  logic         s_tvalid,
	output logic         s_tready,
	// src_id[7:0], dst_id[15:8], sequence_number[79:16],
	// expiry_time_ms[143:80], current_time_ms[207:144]
	input  logic [207:0] s_tdata,
	input  logic         s_tuser,       // source_trusted
	output logic         m_tvalid,
	input  logic         m_tready,
	// received, accepted, bad_source, wrong_target, expired, duplicate, stale
	// totals, 32 bits each from bit 0 up
	output logic [223:0] m_tdata,
	output logic [2:0]   m_tuser        // decision
);
	import gaf_pkg::*;

	logic [7:0]   local_id_q;
	logic         valid_s1;
	grant_t       grant_s1;
	logic         trusted_s1;
	logic         m_valid_q;
	decision_t    decision_q;
	seq_state_t   seq_q;
	decision_t    decision;
	logic         out_free;
	logic         load_out;
	logic         in_take;
	logic [CNT_NUM-1:0] inc;
	cnt_arr_t     counts;

	assign out_free = !m_valid_q || m_tready;
	assign load_out = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign in_take = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_id_q <= '0;
		end else if (cfg_we) begin
			local_id_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (load_out) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			grant_s1 <= grant_t'(s_tdata[GRANT_W-1:0]);
			trusted_s1 <= s_tuser;
		end
	end

	gaf_check u_check (
		.grant     (grant_s1),
		.trusted   (trusted_s1),
		.local_id  (local_id_q),
		.seq_state (seq_q),
		.decision  (decision)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= '0;
		end else if (load_out && (decision == DEC_ACCEPT)) begin
			seq_q.seen_any <= 1'b1;
			seq_q.last_seq <= grant_s1.sequence_number;
		end
	end

	always_comb begin
		inc = '0;
		if (load_out) begin
			inc[CNT_RECEIVED] = 1'b1;
			case (decision)
				DEC_ACCEPT:       inc[CNT_ACCEPTED] = 1'b1;
				DEC_BAD_SOURCE:   inc[CNT_BAD_SOURCE] = 1'b1;
				DEC_WRONG_TARGET: inc[CNT_WRONG_TARGET] = 1'b1;
				DEC_EXPIRED:      inc[CNT_EXPIRED] = 1'b1;
				DEC_DUPLICATE:    inc[CNT_DUPLICATE] = 1'b1;
				DEC_STALE:        inc[CNT_STALE] = 1'b1;
				default:          inc = inc;
			endcase
		end
	end

	gaf_counters u_counters (
		.clk    (clk),
		.arst_n (arst_n),
		.inc    (inc),
		.counts (counts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load_out) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			decision_q <= decision;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser = decision_q;
	assign m_tdata = counts;

`ifndef ASSERT_OFF
	a_acc_le_rcv: assert property (@(posedge clk) disable iff (!arst_n)
		counts[CNT_ACCEPTED] <= counts[CNT_RECEIVED])
		else $error("accepted count exceeds received count");

	a_seq_record: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && (decision == DEC_ACCEPT)) |=>
		(seq_q.seen_any && (seq_q.last_seq == $past(grant_s1.sequence_number))))
		else $error("accepted sequence not recorded");

	a_accept_seen: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && (decision_q == DEC_ACCEPT)) |-> seq_q.seen_any)
		else $error("accept shown with no sequence history");

	a_rcv_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && (counts[CNT_RECEIVED] == '0)) |=> (counts[CNT_RECEIVED] != '0))
		else $error("received count did not advance");
`endif

endmodule

// ----- rtl/gaf_check.sv -----
// Ordered admission checks for one grant item.
module gaf_check (
	input  gaf_pkg::grant_t     grant,
	input  logic                trusted,
	input  logic [7:0]          local_id,
	input  gaf_pkg::seq_state_t seq_state,
	output gaf_pkg::decision_t  decision
);
	import gaf_pkg::*;

	logic bad_src;
	logic wrong_tgt;
	logic expired;
	logic dup;
	logic stale;

	assign bad_src = !trusted || (grant.src_id == '0) || (grant.src_id == local_id);
	assign wrong_tgt = grant.dst_id != local_id;
	assign expired = grant.expiry_time_ms <= grant.current_time_ms;
	assign dup = seq_state.seen_any && (grant.sequence_number == seq_state.last_seq);
	assign stale = seq_state.seen_any && (grant.sequence_number < seq_state.last_seq);

	always_comb begin
		if (bad_src) begin
			decision = DEC_BAD_SOURCE;
		end else if (wrong_tgt) begin
			decision = DEC_WRONG_TARGET;
		end else if (expired) begin
			decision = DEC_EXPIRED;
		end else if (dup) begin
			decision = DEC_DUPLICATE;
		end else if (stale) begin
			decision = DEC_STALE;
		end else begin
			decision = DEC_ACCEPT;
		end
	end

endmodule

// ----- rtl/gaf_counters.sv -----
// Bank of saturating event counters.
module gaf_counters (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [gaf_pkg::CNT_NUM-1:0] inc,
	output gaf_pkg::cnt_arr_t          counts
);
	import gaf_pkg::*;

	cnt_arr_t count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			for (int i = 0; i < CNT_NUM; i++) begin
				if (inc[i] && (count_q[i] != {CNT_W{1'b1}})) begin
					count_q[i] <= count_q[i] + CNT_W'(1);
				end
			end
		end
	end

	assign counts = count_q;

endmodule
